/* hw/rtl/lcdseq_pkg.sv */
// Shared types and constants for the character LCD command sequencer.
`timescale 1ns / 1ps

package lcdseq_pkg;

  localparam int NUM_COLUMNS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int NUM_DIGITS = 5;

  localparam logic [19:0] DELAY_POWER_ON = 20'd800000;
  localparam logic [19:0] DELAY_WAKE_2 = 20'd67200;
  localparam logic [19:0] DELAY_SHORT = 20'd2400;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h04;
  localparam logic [7:0] ENTRY_INCREMENT = 8'h02;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] FUNC_TWO_LINES = 8'h08;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] DDRAM_ROW1 = 8'h40;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

  localparam logic [2:0] FLAG_DISPLAY = 3'b100;
  localparam logic [2:0] FLAG_CURSOR = 3'b010;
  localparam logic [2:0] FLAG_BLINK = 3'b001;

  typedef enum logic [2:0] {
    ACT_INIT = 3'd0,
    ACT_DISPLAY = 3'd1,
    ACT_CURSOR = 3'd2,
    ACT_BLINK = 3'd3,
    ACT_POSITION = 3'd4,
    ACT_CLEAR = 3'd5,
    ACT_CHAR = 3'd6,
    ACT_NUMBER = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    KIND_WAIT = 2'd0,
    KIND_NIBBLE = 2'd1,
    KIND_DELAY = 2'd2
  } kind_t;

  typedef struct packed {
    logic is_init;
    logic rs;
    logic [7:0] data;
    logic last;
  } entry_t;

endpackage

/* hw/rtl/char_lcd_4bit_command_sequencer.sv */
// Top level of the 4-bit character LCD command sequencer.
// Bus operations leave one per cycle unless out_stall holds the output register, and a
// command expands to up to twenty bus operations. A number command converts up to five
// digits in the front end, one digit a cycle.
// The next command is taken while earlier operations drain through the four-entry queue.
// Synchronous reset empties the queue and output register and clears the display flags.
`timescale 1ns / 1ps

module char_lcd_4bit_command_sequencer
  import lcdseq_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic        on,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  input  logic [7:0]  character,
  input  logic [15:0] number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [19:0] delay_count,
  output logic        last
);

  logic q_full, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  lcdseq_front #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .on(on),
    .column(column),
    .row(row),
    .character(character),
    .number(number),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(q_entry)
  );

  lcdseq_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_entry(q_entry),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_head_valid),
    .head(q_head)
  );

  lcdseq_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(q_head_valid),
    .head(q_head),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .reg_select(reg_select),
    .nibble(nibble),
    .delay_count(delay_count),
    .last(last)
  );

`ifndef SYNTH
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  a_wait_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_WAIT) |-> (nibble == 4'd0) && !reg_select && !last)
    else $error("busy wait carries data");

  a_delay_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_DELAY) |-> (delay_count != 20'd0) && !last)
    else $error("delay operation malformed");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* hw/rtl/lcdseq_front.sv */
// Front end: accepts commands, keeps the display flags and queues byte commands.
`timescale 1ns / 1ps

module lcdseq_front
  import lcdseq_pkg::*;
#(
  parameter int NUM_COLUMNS = NUM_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic        on,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  input  logic [7:0]  character,
  input  logic [15:0] number,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_INIT   = 4'b0010,
    F_DIVIDE = 4'b0100,
    F_DIGITS = 4'b1000
  } fstate_t;

  fstate_t state, state_next;
  logic [2:0] flags, flags_next;
  logic [1:0] init_idx, init_idx_next;
  logic [15:0] mag, mag_next;
  logic [2:0] count, count_next;
  logic [3:0] digits [NUM_DIGITS];

  logic accept;
  logic [2:0] flag_bit;
  logic [2:0] flags_upd;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [3:0] rem;
  logic [2:0] rd_idx;
  logic pos_ok;

  assign in_stall = (state != F_IDLE) || q_full;
  assign accept = in_valid && !in_stall;

  assign prod = mag * 16'hCCCD;
  assign quot = prod[31:19];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem = 4'(mag - quot_x10);
  assign rd_idx = count - 3'd1;
  assign pos_ok = (column < 8'(NUM_COLUMNS)) && (row[7:1] == 7'd0);

  always_comb begin
    unique case (action_t'(action))
      ACT_DISPLAY: flag_bit = FLAG_DISPLAY;
      ACT_CURSOR:  flag_bit = FLAG_CURSOR;
      default:     flag_bit = FLAG_BLINK;
    endcase
    flags_upd = on ? (flags | flag_bit) : (flags & ~flag_bit);
  end

  always_comb begin
    state_next = state;
    flags_next = flags;
    init_idx_next = init_idx;
    mag_next = mag;
    count_next = count;
    q_push = 1'b0;
    q_entry = '{is_init: 1'b0, rs: 1'b0, data: CMD_CLEAR, last: 1'b1};
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          unique case (action_t'(action))
            ACT_INIT: begin
              flags_next = FLAG_DISPLAY;
              init_idx_next = 2'd0;
              state_next = F_INIT;
            end
            ACT_DISPLAY, ACT_CURSOR, ACT_BLINK: begin
              flags_next = flags_upd;
              q_push = 1'b1;
              q_entry.data = CMD_DISPLAY_CTRL | {5'd0, flags_upd};
            end
            ACT_POSITION: begin
              q_push = pos_ok;
              q_entry.data = CMD_SET_DDRAM | (row[0] ? DDRAM_ROW1 : 8'h00) | column;
            end
            ACT_CLEAR: begin
              q_push = 1'b1;
            end
            ACT_CHAR: begin
              q_push = 1'b1;
              q_entry.rs = 1'b1;
              q_entry.data = character;
            end
            default: begin
              q_push = number[15];
              q_entry.rs = 1'b1;
              q_entry.data = ASCII_MINUS;
              q_entry.last = 1'b0;
              mag_next = number[15] ? 16'(16'd0 - number) : number;
              count_next = 3'd0;
              state_next = F_DIVIDE;
            end
          endcase
        end
      end
      F_INIT: begin
        q_entry.last = 1'b0;
        unique case (init_idx)
          2'd0: begin
            q_entry.is_init = 1'b1;
            q_entry.data = CMD_FUNCTION_SET | FUNC_TWO_LINES;
          end
          2'd1: q_entry.data = CMD_DISPLAY_CTRL | {5'd0, flags};
          2'd2: q_entry.data = CMD_CLEAR;
          default: begin
            q_entry.data = CMD_ENTRY_MODE | ENTRY_INCREMENT;
            q_entry.last = 1'b1;
          end
        endcase
        if (!q_full) begin
          q_push = 1'b1;
          init_idx_next = init_idx + 2'd1;
          if (init_idx == 2'd3) begin
            state_next = F_IDLE;
          end
        end
      end
      F_DIVIDE: begin
        mag_next = {3'd0, quot};
        count_next = count + 3'd1;
        if ((quot == 13'd0) || (count == 3'(NUM_DIGITS - 1))) begin
          state_next = F_DIGITS;
        end
      end
      F_DIGITS: begin
        q_entry.rs = 1'b1;
        q_entry.data = {ASCII_DIGIT_HI, digits[rd_idx]};
        q_entry.last = (count == 3'd1);
        if (!q_full) begin
          q_push = 1'b1;
          count_next = count - 3'd1;
          if (count == 3'd1) begin
            state_next = F_IDLE;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      flags <= 3'd0;
    end else begin
      state <= state_next;
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    init_idx <= init_idx_next;
    mag <= mag_next;
    count <= count_next;
    if (state == F_DIVIDE) begin
      digits[count] <= rem;
    end
  end

endmodule

/* hw/rtl/lcdseq_queue.sv */
// Short queue of byte commands between the front and back ends.
`timescale 1ns / 1ps

module lcdseq_queue
  import lcdseq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0] fill;
  logic do_push, do_pop;

  assign full = (fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* hw/rtl/lcdseq_back.sv */
// Back end: expands queued byte commands into bus operations, one per cycle unless out_stall holds them.
`timescale 1ns / 1ps

module lcdseq_back
  import lcdseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic        reg_select,
  output logic [3:0]  nibble,
  output logic [19:0] delay_count,
  output logic        last
);

  entry_t cur;
  logic cur_valid;
  logic [3:0] step;
  logic out_free, final_step, emit;

  kind_t op_kind;
  logic op_rs;
  logic [3:0] op_nib;
  logic [19:0] op_delay;

  assign out_free = !out_valid || !out_stall;
  assign final_step = cur.is_init ? (step == 4'd10) : (step == 4'd2);
  assign emit = cur_valid && out_free;
  assign pop = head_valid && (!cur_valid || (emit && final_step));

  always_comb begin
    op_kind = KIND_NIBBLE;
    op_rs = 1'b0;
    op_nib = 4'd0;
    op_delay = 20'd0;
    if (cur.is_init) begin
      unique case (step)
        4'd0: begin
          op_kind = KIND_DELAY;
          op_delay = DELAY_POWER_ON;
        end
        4'd2: begin
          op_kind = KIND_DELAY;
          op_delay = DELAY_WAKE_2;
        end
        4'd4, 4'd6, 4'd8: begin
          op_kind = KIND_DELAY;
          op_delay = DELAY_SHORT;
        end
        4'd1, 4'd3, 4'd5: op_nib = NIB_WAKE;
        4'd7: op_nib = NIB_FOUR_BIT;
        4'd9: op_nib = cur.data[7:4];
        default: op_nib = cur.data[3:0];
      endcase
    end else begin
      unique case (step)
        4'd0: op_kind = KIND_WAIT;
        4'd1: begin
          op_rs = cur.rs;
          op_nib = cur.data[7:4];
        end
        default: begin
          op_rs = cur.rs;
          op_nib = cur.data[3:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        step <= 4'd0;
      end else if (emit) begin
        if (final_step) begin
          cur_valid <= 1'b0;
        end
        step <= step + 4'd1;
      end
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      kind <= op_kind;
      reg_select <= op_rs;
      nibble <= op_nib;
      delay_count <= op_delay;
      last <= final_step && cur.last;
    end
  end

endmodule
